/* design/tlbf_pkg.sv */
// Shared types, constants and helper functions of the hop-limited flood block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tlbf_pkg;

    localparam int NODES   = 64;
    localparam int NODE_W  = $clog2(NODES);
    localparam int LEVEL_W = 8;
    localparam int HOP_W   = 9;
    localparam int COUNT_W = 32;
    localparam int ROW_W   = 64;
    localparam int IDX_W   = 6;
    localparam int OP_W    = 2;
    localparam int DELTA_W = NODE_W + 2;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [PADDR_W-1:0]     ADDR_HOP_LIMIT = 3'd0;
    localparam logic signed [HOP_W-1:0] HOP_ALL       = -9'sd1;
    localparam logic signed [HOP_W-1:0] HOP_RESET     = -9'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_BROADCAST = 2'd1,
        OP_FORGET    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEVEL_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic write_row;
        logic start_flood;
        logic forget;
        logic issue;
        logic advance;
        logic push_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic node_ok;
        logic frontier_empty;
        logic next_empty;
        logic level_ok;
        logic p1_busy;
        logic p2_busy;
        logic out_free;
    } dp_status_t;

    function automatic logic [NODE_W-1:0] first_set(input logic [NODES-1:0] v);
        logic [NODE_W-1:0] r;
        r = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = NODE_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [NODE_W:0] count_ones(input logic [NODES-1:0] v);
        logic [NODE_W:0] c;
        c = '0;
        for (int i = 0; i < NODES; i++)
        begin
            c = c + (NODE_W + 1)'(v[i]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/tlbf_ctrl.sv */
// Controller state machine of the hop-limited flood block.
// Depends on tlbf_pkg; drives commands to tlbf_datapath and reads its status.
`default_nettype none

module tlbf_ctrl
    import tlbf_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [OP_W-1:0] operation,
    input  dp_status_t           status,
    output logic                 in_ready,
    output ctrl_cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_FINISH;
                    case (op_t'(operation))
                        OP_WRITE:
                        begin
                            cmd.write_row = status.node_ok;
                        end
                        OP_BROADCAST:
                        begin
                            if (status.node_ok)
                            begin
                                cmd.start_flood = 1'b1;
                                state_next      = ST_SCAN;
                            end
                        end
                        OP_FORGET:
                        begin
                            cmd.forget = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.level_ok && !status.frontier_empty)
                begin
                    cmd.issue = 1'b1;
                end
                else
                begin
                    state_next = ST_LEVEL_END;
                end
            end
            ST_LEVEL_END:
            begin
                if (!status.p1_busy)
                begin
                    if (!status.next_empty)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!status.p2_busy && status.out_free)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/tlbf_datapath.sv */
// Datapath of the hop-limited flood block: adjacency memory, frontier, visited
// mask, crossed-edge count and the output register. Depends on tlbf_pkg.
`default_nettype none

module tlbf_datapath
    import tlbf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  ctrl_cmd_t                      cmd,
    input  wire logic [IDX_W-1:0]          node_index,
    input  wire logic [ROW_W-1:0]          neighbor_row,
    input  wire logic signed [HOP_W-1:0]   hop_limit,
    input  wire logic                      out_ready,
    output dp_status_t                     status,
    output logic                           out_valid,
    output logic [ROW_W-1:0]               visited_set,
    output logic signed [COUNT_W-1:0]      edges_crossed
);

    logic [NODES-1:0]          adj_mem [NODES];
    logic [NODES-1:0]          row_vld_reg;
    logic [NODES-1:0]          rd_row_reg;
    logic                      rd_ok_reg;
    logic                      p1_valid_reg;
    logic [DELTA_W-1:0]        delta_reg;
    logic                      p2_valid_reg;
    logic [NODES-1:0]          frontier_reg;
    logic [NODES-1:0]          next_reg;
    logic [NODES-1:0]          visited_reg;
    logic [LEVEL_W-1:0]        level_reg;
    logic signed [COUNT_W-1:0] count_reg;
    logic [NODES-1:0]          visited_set_reg;
    logic signed [COUNT_W-1:0] edges_crossed_reg;
    logic                      out_valid_reg;

    logic [NODE_W-1:0]         node_addr;
    logic [NODE_W-1:0]         pick;
    logic [NODES-1:0]          row_eff;
    logic [NODES-1:0]          fresh;
    logic [COUNT_W:0]          sum;
    logic signed [COUNT_W-1:0] count_sat;

    assign node_addr = node_index[NODE_W-1:0];
    assign pick      = first_set(frontier_reg);
    assign row_eff   = rd_ok_reg ? rd_row_reg : '0;
    assign fresh     = row_eff & ~visited_reg;

    assign sum = {count_reg[COUNT_W-1], count_reg}
               + {{(COUNT_W + 1 - DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg};

    always_comb
    begin
        if (sum[COUNT_W] != sum[COUNT_W-1])
        begin
            count_sat = sum[COUNT_W] ? {1'b1, {(COUNT_W-1){1'b0}}}
                                     : {1'b0, {(COUNT_W-1){1'b1}}};
        end
        else
        begin
            count_sat = sum[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        status.node_ok        = ({1'b0, node_index} < (IDX_W + 1)'(NODES));
        status.frontier_empty = (frontier_reg == '0);
        status.next_empty     = (next_reg == '0);
        status.level_ok       = (hop_limit == HOP_ALL)
                             || ($signed({1'b0, level_reg}) < hop_limit);
        status.p1_busy        = p1_valid_reg;
        status.p2_busy        = p2_valid_reg;
        status.out_free       = !out_valid_reg || out_ready;
    end

    // Adjacency rows; a row that was never written reads as empty through its valid bit.
    always_ff @(posedge clk)
    begin
        if (cmd.write_row)
        begin
            adj_mem[node_addr] <= neighbor_row[NODES-1:0];
        end
        if (cmd.issue)
        begin
            rd_row_reg <= adj_mem[pick];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            rd_ok_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            frontier_reg  <= '0;
            next_reg      <= '0;
            visited_reg   <= '0;
            level_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_row)
            begin
                row_vld_reg[node_addr] <= 1'b1;
            end
            if (cmd.issue)
            begin
                rd_ok_reg <= row_vld_reg[pick];
            end
            p1_valid_reg <= cmd.issue;
            p2_valid_reg <= p1_valid_reg;

            if (cmd.forget)
            begin
                visited_reg <= '0;
            end
            else if (cmd.start_flood)
            begin
                visited_reg <= visited_reg | (NODES'(1) << node_addr);
            end
            else if (p1_valid_reg)
            begin
                visited_reg <= visited_reg | fresh;
            end

            if (cmd.start_flood)
            begin
                frontier_reg <= NODES'(1) << node_addr;
                next_reg     <= '0;
                level_reg    <= '0;
            end
            else if (cmd.advance)
            begin
                frontier_reg <= next_reg;
                next_reg     <= '0;
                level_reg    <= level_reg + LEVEL_W'(1);
            end
            else
            begin
                if (cmd.issue)
                begin
                    frontier_reg[pick] <= 1'b0;
                end
                if (p1_valid_reg)
                begin
                    next_reg <= next_reg | fresh;
                end
            end

            if (cmd.forget)
            begin
                count_reg <= '0;
            end
            else if (p2_valid_reg)
            begin
                count_reg <= count_sat;
            end

            if (cmd.push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            delta_reg <= {1'b0, count_ones(row_eff)} - DELTA_W'(1);
        end
        if (cmd.push_out)
        begin
            visited_set_reg   <= visited_reg;
            edges_crossed_reg <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign visited_set   = ROW_W'(visited_set_reg);
    assign edges_crossed = edges_crossed_reg;

endmodule

`default_nettype wire

/* design/ttl_limited_bfs_flood.sv */
// Top level of the hop-limited breadth-first flood block: APB register, controller
// and datapath. Depends on tlbf_pkg, tlbf_ctrl and tlbf_datapath.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid / in_ready     | operation, node_index, neighbor_row
//   output   | out_valid / out_ready   | visited_set, edges_crossed
//   config   | psel, penable, pwrite   | paddr, pwdata, prdata (hop_limit at 0x0)
//
// A row write, a forget or an ignored transaction goes from ST_IDLE to ST_FINISH.
// A broadcast reads one frontier row per cycle from the adjacency memory port in
// ST_SCAN; a level ends once the frontier is empty or the hop limit is reached, and
// ST_LEVEL_END lets the first pipeline stage settle before advancing or finishing.
// Reset clears all state at once through per-row valid bits; there is no clearing pass.
// A finished result waits in the output register; the next transaction is taken
// while it waits, and only a later result stalls on it.
`default_nettype none

module ttl_limited_bfs_flood
    import tlbf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [OP_W-1:0]        operation,
    input  wire logic [IDX_W-1:0]       node_index,
    input  wire logic [ROW_W-1:0]       neighbor_row,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [ROW_W-1:0]            visited_set,
    output logic signed [COUNT_W-1:0]   edges_crossed,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [APB_W-1:0]       pwdata,
    output logic [APB_W-1:0]            prdata,
    output logic                        pready
);

    logic signed [HOP_W-1:0] hop_limit_reg;
    ctrl_cmd_t               cmd;
    dp_status_t              status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_limit_reg <= HOP_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_HOP_LIMIT))
        begin
            hop_limit_reg <= pwdata[HOP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_HOP_LIMIT: prdata = {{(APB_W-HOP_W){hop_limit_reg[HOP_W-1]}}, hop_limit_reg};
            default:        prdata = '0;
        endcase
    end

    tlbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    tlbf_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .node_index    (node_index),
        .neighbor_row  (neighbor_row),
        .hop_limit     (hop_limit_reg),
        .out_ready     (out_ready),
        .status        (status),
        .out_valid     (out_valid),
        .visited_set   (visited_set),
        .edges_crossed (edges_crossed)
    );

    // The controller is not ready in the cycle after it takes a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on two consecutive cycles");

    // A row is fetched only while the level may still expand and a frontier node remains.
    a_issue_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> status.level_ok && !status.frontier_empty)
        else $error("row fetch outside an allowed level");

    // A result is published only after the expansion pipeline has drained.
    a_push_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_out |-> !status.p1_busy && !status.p2_busy && status.out_free)
        else $error("result published with work in flight");

endmodule

`default_nettype wire

/* test/tb_ttl_limited_bfs_flood.sv */
// Self-checking testbench of the hop-limited breadth-first flood block.
// Drives row writes, broadcasts and forgets under several hop limits and checks every
// result against an in-bench flood predictor; depends on tlbf_pkg and ttl_limited_bfs_flood.
`default_nettype none

module tb_ttl_limited_bfs_flood;
    import tlbf_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 110;
    localparam int CALM_ITEMS = 150;
    localparam longint CROSSED_MAX = 64'sd2147483647;
    localparam longint CROSSED_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] node;
        logic [ROW_W-1:0] row;
    } flood_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]          visited;
        logic signed [COUNT_W-1:0] crossed;
    } flood_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [OP_W-1:0] operation;
    logic [IDX_W-1:0] node_index;
    logic [ROW_W-1:0] neighbor_row;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ROW_W-1:0] visited_set;
    logic signed [COUNT_W-1:0] edges_crossed;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0] pwdata = '0;
    logic [APB_W-1:0] prdata;
    logic pready;

    flood_item_t item_on_wire = '0;
    flood_item_t item_backlog [$];
    flood_outcome_t flood_expect [$];
    flood_outcome_t predicted;
    flood_outcome_t want;

    logic [ROW_W-1:0] adj_mirror [NODES];
    logic [ROW_W-1:0] seen_mirror;
    longint crossed_mirror;
    int hop_mirror;

    int send_gap = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    bit calm = 1'b0;
    int hop_plan [10] = '{0, 1, 2, 3, 255, -256, -2, 5, 4, -1};

    assign operation    = item_on_wire.op;
    assign node_index   = item_on_wire.node;
    assign neighbor_row = item_on_wire.row;

    ttl_limited_bfs_flood u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .node_index(node_index),
        .neighbor_row(neighbor_row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .visited_set(visited_set),
        .edges_crossed(edges_crossed),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic predict_flood(input flood_item_t it, output flood_outcome_t res);
        logic [ROW_W-1:0] frontier;
        logic [ROW_W-1:0] upcoming;
        logic [ROW_W-1:0] fresh;
        logic [ROW_W-1:0] nbrs;
        int level;
        if (it.op == OP_WRITE)
        begin
            adj_mirror[it.node] = it.row;
        end
        else if (it.op == OP_BROADCAST)
        begin
            frontier = ROW_W'(1) << it.node;
            seen_mirror = seen_mirror | frontier;
            level = 0;
            while (frontier != '0 && (hop_mirror == HOP_ALL || level < hop_mirror))
            begin
                upcoming = '0;
                for (int i = 0; i < NODES; i++)
                begin
                    if (frontier[i])
                    begin
                        nbrs = adj_mirror[i];
                        fresh = nbrs & ~seen_mirror;
                        seen_mirror = seen_mirror | fresh;
                        upcoming = upcoming | fresh;
                        crossed_mirror = crossed_mirror + $countones(nbrs) - 1;
                        if (crossed_mirror > CROSSED_MAX)
                        begin
                            crossed_mirror = CROSSED_MAX;
                        end
                        if (crossed_mirror < CROSSED_MIN)
                        begin
                            crossed_mirror = CROSSED_MIN;
                        end
                    end
                end
                frontier = upcoming;
                level++;
            end
        end
        else if (it.op == OP_FORGET)
        begin
            seen_mirror = '0;
            crossed_mirror = 0;
        end
        res.visited = seen_mirror;
        res.crossed = crossed_mirror[COUNT_W-1:0];
    endtask

    // Input driver: holds each transaction until accepted, with random idle bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                predict_flood(item_on_wire, predicted);
                flood_expect.push_back(predicted);
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (item_backlog.size() != 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                send_gap <= $urandom_range(0, 6);
                in_valid <= 1'b0;
            end
            else if (item_backlog.size() != 0)
            begin
                item_on_wire <= item_backlog.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: compares each result with the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (flood_expect.size() == 0)
                begin
                    $display("%0t: result with no transaction waiting: visited %h, count %0d",
                             $time, visited_set, edges_crossed);
                    mismatches++;
                end
                else
                begin
                    want = flood_expect.pop_front();
                    if (visited_set !== want.visited)
                    begin
                        $display("%0t: visited_set expected %h, actual %h",
                                 $time, want.visited, visited_set);
                        mismatches++;
                    end
                    if (edges_crossed !== want.crossed)
                    begin
                        $display("%0t: edges_crossed expected %0d, actual %0d",
                                 $time, want.crossed, edges_crossed);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                hold_left <= $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_ttl_limited_bfs_flood: done, errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] node,
                              input logic [ROW_W-1:0] row);
        flood_item_t it;
        it.op = op;
        it.node = node;
        it.row = row;
        item_backlog.push_back(it);
    endtask

    function automatic logic [ROW_W-1:0] make_row();
        int style;
        logic [ROW_W-1:0] r;
        style = $urandom_range(0, 99);
        r = '0;
        if (style < 4)
        begin
            r = '0;
        end
        else if (style < 7)
        begin
            r = '1;
        end
        else if (style < 17)
        begin
            r = {$urandom, $urandom};
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                r[$urandom_range(0, NODES - 1)] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (item_backlog.size() != 0 || in_valid || flood_expect.size() != 0);
    endtask

    task automatic set_hop_limit(input logic signed [HOP_W-1:0] value);
        logic [APB_W-HOP_W-1:0] spare;
        spare = ($urandom_range(0, 1) == 1) ? (APB_W - HOP_W)'($urandom) : '0;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_HOP_LIMIT;
        pwdata <= {spare, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'($urandom);
        pwdata <= $urandom;
        hop_mirror = value;
    endtask

    initial
    begin
        int pushed;
        int pick;
        int start;
        int run;
        logic [IDX_W-1:0] at;
        logic [ROW_W-1:0] row;
        for (int i = 0; i < NODES; i++)
        begin
            adj_mirror[i] = '0;
        end
        seen_mirror = '0;
        crossed_mirror = 0;
        hop_mirror = HOP_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset hop limit (unlimited).
        queue_item(OP_BROADCAST, 6'd0, '0);
        queue_item(OP_WRITE, 6'd0, '1);
        queue_item(OP_BROADCAST, 6'd0, '1);
        queue_item(OP_FORGET, 6'd63, '1);
        queue_item(OP_WRITE, 6'd63, ROW_W'(1) << 63);
        queue_item(OP_BROADCAST, 6'd63, '0);
        queue_item(OP_WRITE, 6'd1, ROW_W'(1) << 2);
        queue_item(OP_WRITE, 6'd2, ROW_W'(1) << 3);
        queue_item(OP_WRITE, 6'd3, ROW_W'(1) << 1);
        queue_item(OP_BROADCAST, 6'd1, '0);
        queue_item(OP_IGNORED, 6'd63, '1);
        queue_item(OP_WRITE, 6'd5, '0);
        queue_item(OP_BROADCAST, 6'd5, '0);
        queue_item(OP_FORGET, 6'd0, '0);
        queue_item(OP_WRITE, 6'd0, ROW_W'(1) << 1);
        queue_item(OP_BROADCAST, 6'd0, '0);
        queue_item(OP_IGNORED, 6'd0, '0);
        wait_drained();

        hop_plan[7] = $urandom_range(0, 511) - 256;
        for (int p = 0; p < 10; p++)
        begin
            set_hop_limit(HOP_W'(hop_plan[p]));
            calm = (p == 9);
            queue_item(OP_FORGET, 6'd0, '0);
            queue_item(OP_BROADCAST, 6'd1, '0);
            queue_item(OP_BROADCAST, 6'd63, '1);
            pushed = 0;
            while (pushed < (calm ? CALM_ITEMS : PHASE_ITEMS))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        queue_item(OP_WRITE, IDX_W'($urandom), make_row());
                        pushed++;
                    end
                end
                else if (pick < 42)
                begin
                    start = $urandom_range(0, NODES - 1);
                    run = $urandom_range(3, 12);
                    for (int j = 0; j < run; j++)
                    begin
                        at = IDX_W'(start + j);
                        row = ROW_W'(1) << IDX_W'(start + j + 1);
                        if ($urandom_range(0, 3) == 0)
                        begin
                            row[$urandom_range(0, NODES - 1)] = 1'b1;
                        end
                        queue_item(OP_WRITE, at, row);
                    end
                    queue_item(OP_BROADCAST, IDX_W'(start), {$urandom, $urandom});
                    pushed += run + 1;
                end
                else if (pick < 80)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        queue_item(OP_BROADCAST, IDX_W'($urandom), {$urandom, $urandom});
                        pushed++;
                    end
                end
                else if (pick < 90)
                begin
                    queue_item(OP_FORGET, IDX_W'($urandom), {$urandom, $urandom});
                    pushed++;
                end
                else if (pick < 95)
                begin
                    queue_item(OP_IGNORED, IDX_W'($urandom), {$urandom, $urandom});
                end
                else
                begin
                    queue_item(OP_W'($urandom), IDX_W'($urandom), {$urandom, $urandom});
                    pushed++;
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && flood_expect.size() == 0)
        begin
            $display("tb_ttl_limited_bfs_flood: done, clean");
        end
        else
        begin
            $display("tb_ttl_limited_bfs_flood: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
